// ----- hw/rtl/pcm_pkg.sv -----
package pcm_pkg;

  localparam int FIELD_W    = 32;
  localparam int CB_W       = 5;
  localparam int WB_W       = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CB_W-1:0] CB_RESET = CB_W'(8);
  localparam logic [WB_W-1:0] WB_RESET = WB_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_BITS = 1'b0,
    REG_WORD_BITS    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pcm_adv_t;

endpackage

// ----- hw/rtl/pcm_ifs.sv -----
interface pcm_operand_if;
  logic                        valid;
  logic                        ready;
  logic [pcm_pkg::FIELD_W-1:0] operand_a;
  logic [pcm_pkg::FIELD_W-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface pcm_product_if;
  logic                        valid;
  logic                        ready;
  logic [pcm_pkg::FIELD_W-1:0] product_word;

  modport source (output valid, output product_word, input ready);
  modport sink (input valid, input product_word, output ready);
endinterface

interface pcm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcm_pkg::CFG_IDX_W-1:0]  index;
  logic [pcm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/pcm_extract.sv -----
module pcm_extract #(
  parameter int WW   = 32,
  parameter int MCB  = 16,
  parameter int LW   = 16,
  parameter int LANE = 0
) (
  input  logic                      clk,
  input  pcm_pkg::pcm_adv_t         adv,
  input  logic [pcm_pkg::CB_W-1:0]  n,
  input  logic [pcm_pkg::WB_W-1:0]  wbc,
  input  logic                      n_ok,
  input  logic [WW-1:0]             a,
  input  logic [WW-1:0]             b,
  output logic [LW-1:0]             ca,
  output logic [LW-1:0]             cb,
  output logic                      en
);
  import pcm_pkg::*;

  localparam int SH_W = $clog2(WW * MCB + 1);

  logic [SH_W:0]   span;
  logic [SH_W-1:0] sh;
  logic [LW-1:0]   cmask;
  logic [LW-1:0]   ca_next;
  logic [LW-1:0]   cb_next;
  logic            en_next;

  always_comb begin
    span    = (SH_W+1)'(LANE + 1) * (SH_W+1)'(n);
    sh      = SH_W'(LANE) * SH_W'(n);
    cmask   = ~({LW{1'b1}} << n);
    en_next = n_ok && (span <= (SH_W+1)'(wbc));
    ca_next = LW'(a >> sh) & cmask;
    cb_next = LW'(b >> sh) & cmask;
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ca <= ca_next;
      cb <= cb_next;
      en <= en_next;
    end
  end

endmodule

// ----- hw/rtl/pcm_lane.sv -----
module pcm_lane #(
  parameter int MCB = 16,
  parameter int LW  = 16
) (
  input  logic                      clk,
  input  pcm_pkg::pcm_adv_t         adv,
  input  logic [pcm_pkg::CB_W-1:0]  n,
  input  logic [LW-1:0]             ca,
  input  logic [LW-1:0]             cb,
  input  logic                      en,
  output logic [MCB-1:0]            r_out
);
  import pcm_pkg::*;

  localparam int PW = 2 * LW;

  logic [PW-1:0] p;
  logic          en2;
  logic [LW-1:0] r;

  logic [PW-1:0] half;
  logic [PW-1:0] p_next;
  logic [PW:0]   q;
  logic [LW-1:0] cmask;
  logic [LW-1:0] r_next;

  always_comb begin
    half   = PW'(1) << (n - CB_W'(1));
    p_next = PW'(ca) * PW'(cb) + half;
  end

  always_comb begin
    q      = (PW+1)'(p) + ((PW+1)'(p) >> n);
    cmask  = ~({LW{1'b1}} << n);
    r_next = en2 ? (LW'(q >> n) & cmask) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      p   <= p_next;
      en2 <= en;
    end
    if (adv.s3) begin
      r <= r_next;
    end
  end

  assign r_out = MCB'(r);

endmodule

// ----- hw/rtl/pcm_pack.sv -----
module pcm_pack #(
  parameter int WW  = 32,
  parameter int MCB = 16
) (
  input  logic                         clk,
  input  pcm_pkg::pcm_adv_t            adv,
  input  logic [pcm_pkg::CB_W-1:0]     n,
  input  logic [MCB-1:0]               r [WW],
  output logic [pcm_pkg::FIELD_W-1:0]  word
);
  import pcm_pkg::*;

  localparam int SH_W = $clog2(WW * MCB + 1);

  logic [SH_W-1:0] sh [WW];
  logic [WW-1:0]   acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < WW; i++) begin
      sh[i] = SH_W'(i) * SH_W'(n);
      acc   = acc | WW'({{WW{1'b0}}, r[i]} << sh[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      word <= FIELD_W'(acc);
    end
  end

endmodule

// ----- hw/rtl/packed_channel_multiply.sv -----
// Partitioned multiply of packed unsigned channels: each beat carries two words whose
// low word_bits bits hold floor(word_bits / channel_bits) channels, channel 0 at bit 0,
// and the result packs round(a * b / (2^n - 1)) per channel with unused high bits zero
// (zero overall when channel_bits is 0, above MAX_CHANNEL_BITS, or wider than word_bits).
// The block takes one beat every cycle while the output accepts, through four register
// stages (channel extract, lane multiply, normalize, pack); a result is valid at the
// output once the pack stage register holds it, until accepted. One multiplier per lane
// sets the stage depth. Backpressure holds the occupied stages from the output back to the
// first empty one, so bubbles close up and nothing is dropped. Configuration writes are
// taken at any time, always ready, and must land only while no beat is in flight.
module packed_channel_multiply #(
  parameter int WORD_WIDTH       = 32,
  parameter int MAX_CHANNEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  pcm_operand_if.sink           operands,
  pcm_product_if.source         products,
  pcm_cfg_if.sink               cfg
);
  import pcm_pkg::*;

  localparam int NL = WORD_WIDTH;

  logic [CB_W-1:0] channel_bits;
  logic [WB_W-1:0] word_bits;

  logic valid_s1;
  logic valid_s2;
  logic valid_s3;
  logic valid_s4;

  pcm_adv_t adv;

  logic [WB_W-1:0]             wbc;
  logic                        n_ok;
  logic [MAX_CHANNEL_BITS-1:0] lane_r [NL];
  logic [FIELD_W-1:0]          word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_bits <= CB_RESET;
      word_bits    <= WB_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CHANNEL_BITS: channel_bits <= cfg.data[CB_W-1:0];
        REG_WORD_BITS:    word_bits    <= cfg.data[WB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wbc  = (word_bits > WB_W'(WORD_WIDTH)) ? WB_W'(WORD_WIDTH) : word_bits;
    n_ok = (channel_bits != '0) && (channel_bits <= CB_W'(MAX_CHANNEL_BITS));
  end

  always_comb begin
    adv.s4 = !valid_s4 || products.ready;
    adv.s3 = !valid_s3 || adv.s4;
    adv.s2 = !valid_s2 || adv.s3;
    adv.s1 = !valid_s1 || adv.s2;
  end

  assign operands.ready = adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
      valid_s3 <= 1'b0;
      valid_s4 <= 1'b0;
    end else begin
      if (adv.s1) valid_s1 <= operands.valid;
      if (adv.s2) valid_s2 <= valid_s1;
      if (adv.s3) valid_s3 <= valid_s2;
      if (adv.s4) valid_s4 <= valid_s3;
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_lane
    localparam int LW = (MAX_CHANNEL_BITS < WORD_WIDTH / (i + 1)) ?
                        MAX_CHANNEL_BITS : WORD_WIDTH / (i + 1);

    logic [LW-1:0] ca;
    logic [LW-1:0] cb;
    logic          en;

    pcm_extract #(
      .WW   (WORD_WIDTH),
      .MCB  (MAX_CHANNEL_BITS),
      .LW   (LW),
      .LANE (i)
    ) u_extract (
      .clk  (clk),
      .adv  (adv),
      .n    (channel_bits),
      .wbc  (wbc),
      .n_ok (n_ok),
      .a    (operands.operand_a[WORD_WIDTH-1:0]),
      .b    (operands.operand_b[WORD_WIDTH-1:0]),
      .ca   (ca),
      .cb   (cb),
      .en   (en)
    );

    pcm_lane #(
      .MCB (MAX_CHANNEL_BITS),
      .LW  (LW)
    ) u_lane (
      .clk   (clk),
      .adv   (adv),
      .n     (channel_bits),
      .ca    (ca),
      .cb    (cb),
      .en    (en),
      .r_out (lane_r[i])
    );
  end

  pcm_pack #(
    .WW  (WORD_WIDTH),
    .MCB (MAX_CHANNEL_BITS)
  ) u_pack (
    .clk  (clk),
    .adv  (adv),
    .n    (channel_bits),
    .r    (lane_r),
    .word (word)
  );

  assign products.valid        = valid_s4;
  assign products.product_word = word;

endmodule

// ----- dv/packed_channel_multiply_check.sv -----
`timescale 1ns / 100ps

module packed_channel_multiply_check (
  input  logic   clk,
  input  logic   rst,
  pcm_operand_if operands,
  pcm_product_if products,
  pcm_cfg_if     cfg,
  output int     errors,
  output int     checked,
  output int     pending
);
  import pcm_pkg::*;

  localparam int WORD_W = 32;
  localparam int MAX_CB = 16;

  logic [CB_W-1:0]    chan_bits;
  logic [WB_W-1:0]    word_span;
  logic [FIELD_W-1:0] products_due[$];
  logic [FIELD_W-1:0] want;
  int                 mismatch_count = 0;
  int                 compare_count = 0;

  function automatic logic [FIELD_W-1:0] scaled_product(input logic [FIELD_W-1:0] a,
                                                        input logic [FIELD_W-1:0] b,
                                                        input logic [CB_W-1:0]    n,
                                                        input logic [WB_W-1:0]    wb);
    logic [63:0] lane_mask;
    logic [63:0] lane_a;
    logic [63:0] lane_b;
    logic [63:0] biased;
    logic [63:0] folded;
    logic [63:0] acc;
    int          lanes;
    int          sh;
    int          width;
    int          span;
    acc   = '0;
    width = int'(n);
    span  = (int'(wb) > WORD_W) ? WORD_W : int'(wb);
    if (width >= 1 && width <= MAX_CB) begin
      lane_mask = (64'd1 << width) - 64'd1;
      lanes     = span / width;
      for (int i = 0; i < lanes; i++) begin
        sh     = i * width;
        lane_a = ({32'd0, a} >> sh) & lane_mask;
        lane_b = ({32'd0, b} >> sh) & lane_mask;
        biased = lane_a * lane_b + (64'd1 << (width - 1));
        folded = biased + (biased >> width);
        acc    = acc | (((folded >> width) & lane_mask) << sh);
      end
    end
    return acc[FIELD_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      chan_bits <= CB_W'(8);
      word_span <= WB_W'(32);
      products_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_CHANNEL_BITS) begin
          chan_bits <= cfg.data[CB_W-1:0];
        end else begin
          word_span <= cfg.data[WB_W-1:0];
        end
      end
      if (products.valid && products.ready) begin
        if (products_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: product beat with nothing expected, expected none, actual %h",
                   $time, products.product_word);
        end else begin
          want = products_due.pop_front();
          compare_count++;
          if (products.product_word !== want) begin
            mismatch_count++;
            $display("%0t: product_word mismatch, expected %h, actual %h",
                     $time, want, products.product_word);
          end
        end
      end
      if (operands.valid && operands.ready) begin
        products_due.push_back(scaled_product(operands.operand_a, operands.operand_b,
                                              chan_bits, word_span));
      end
    end
    errors  <= mismatch_count;
    checked <= compare_count;
    pending <= products_due.size();
  end
endmodule

// ----- dv/packed_channel_multiply_test.sv -----
`timescale 1ns / 100ps

module packed_channel_multiply_test;
  import pcm_pkg::*;

  localparam int ITEMS       = 1050;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN       = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcm_operand_if operands ();
  pcm_product_if products ();
  pcm_cfg_if     cfg ();

  int errors;
  int checked;
  int pending;
  int src_idle = 35;
  int snk_idle = 63;
  int sent = 0;
  int settings = 0;
  int writes = 0;
  int quiet = 0;
  int cur_width = 8;

  always #6 clk = ~clk;

  packed_channel_multiply i_dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .products (products),
    .cfg      (cfg)
  );

  packed_channel_multiply_check i_check (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .products (products),
    .cfg      (cfg),
    .errors   (errors),
    .checked  (checked),
    .pending  (pending)
  );

  initial begin
    products.ready = 1'b0;
    forever begin
      @(posedge clk);
      products.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((operands.valid && operands.ready) || (products.valid && products.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet <= 0;
      end else if (quiet + 1 >= STALL_LIMIT) begin
        $display("packed_channel_multiply_test: done, errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      operands.valid <= 1'b0;
      @(posedge clk);
    end
    operands.valid     <= 1'b1;
    operands.operand_a <= a;
    operands.operand_b <= b;
    @(posedge clk);
    while (!operands.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    writes++;
  endtask

  // hold until every product has drained, then load both registers
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] width_val,
                               input logic [CFG_DATA_W-1:0] span_val);
    operands.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_CHANNEL_BITS, width_val);
    write_reg(REG_WORD_BITS, span_val);
    cfg.valid <= 1'b0;
    cur_width = int'(width_val[CB_W-1:0]);
    settings++;
  endtask

  function automatic logic [FIELD_W-1:0] pick_operand(input int width);
    logic [FIELD_W-1:0] w;
    logic [FIELD_W-1:0] lane;
    int                 kind;
    kind = $urandom_range(0, 3);
    w    = $urandom;
    if (kind == 1 && width >= 1 && width <= 16) begin
      lane = (32'h1 << width) - 32'h1;
      for (int sh = 0; sh < FIELD_W; sh += width) begin
        case ($urandom_range(0, 2))
          0: w = w & ~(lane << sh);
          1: w = w | (lane << sh);
          default: ;
        endcase
      end
    end else if (kind == 2) begin
      w = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      w = w ^ (32'h1 << $urandom_range(0, 31));
    end
    return w;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] width_val;
    logic [CFG_DATA_W-1:0] span_val;
    int                    pick;
    int                    count;
    operands.valid     <= 1'b0;
    operands.operand_a <= '0;
    operands.operand_b <= '0;
    cfg.valid          <= 1'b0;
    cfg.index          <= REG_CHANNEL_BITS;
    cfg.data           <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    send_pair(32'hffff_ffff, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'hffff_ffff);
    send_pair(32'haaaa_aaaa, 32'h5555_5555);
    send_pair(32'h80ff_017f, 32'hff80_fe01);
    apply_setting(6'd16, 6'd32);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    send_pair(32'h0001_ffff, 32'h8000_fffe);
    apply_setting(6'd1, 6'd1);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    send_pair(32'h0000_0001, 32'h0000_0001);
    // width field masks to zero
    apply_setting(6'h20, 6'd32);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    apply_setting(6'd17, 6'd32);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    apply_setting(6'h3f, 6'h3f);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    apply_setting(6'd16, 6'd15);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    apply_setting(6'd5, 6'd0);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    apply_setting(6'd3, 6'h3f);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    send_pair(32'h9249_2492, 32'hdb6d_b6db);
    apply_setting(6'd1, 6'd32);
    send_pair(32'hf0f0_0f0f, 32'hff00_ff00);
    send_pair(32'hffff_ffff, 32'h7fff_fffe);

    while (sent < ITEMS) begin
      if (sent >= 2 * ITEMS / 3) begin
        src_idle = 0;
        snk_idle = 0;
      end else if (sent >= ITEMS / 3) begin
        src_idle = 63;
        snk_idle = 35;
      end
      pick = $urandom_range(0, 9);
      width_val = CFG_DATA_W'($urandom_range(1, 16));
      if (pick < 7) begin
        span_val = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 63))
                                               : CFG_DATA_W'($urandom_range(24, 32));
      end else if (pick == 7) begin
        width_val = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(0)
                                                : CFG_DATA_W'($urandom_range(17, 31));
        span_val  = CFG_DATA_W'($urandom_range(0, 63));
      end else begin
        span_val = CFG_DATA_W'($urandom_range(33, 63));
      end
      width_val[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
      apply_setting(width_val, span_val);
      count = $urandom_range(10, 60);
      for (int k = 0; k < count; k++) begin
        send_pair(pick_operand(cur_width), pick_operand(cur_width));
      end
    end

    operands.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d operand beats over %0d register settings, %0d register writes",
             sent, settings, writes);
    $display("compared %0d product words, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("packed_channel_multiply_test: done, clean");
    end else begin
      $display("packed_channel_multiply_test: done, errors");
    end
    $finish;
  end
endmodule
